FILE: hdl/hrc_pkg.sv
// shared types, constants and coefficient tables for the hue-rotate colour matrix
`default_nettype none

package hrc_pkg;

    // fixed-point format of the angle registers and the matrix coefficients
    localparam int FRAC_BITS = 14;
    localparam int CFG_W     = 16;
    localparam int CH_W      = 8;
    localparam int NUM_COEF  = 9;
    localparam int NUM_LANES = 3;

    // register indexes of the configuration port
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_ANGLE = 1'b0,
        CFG_SIN_ANGLE = 1'b1
    } cfg_reg_e;

    // matrix constants in thousandths, row major (red row, green row, blue row)
    localparam int BASE_K [NUM_COEF] = '{213, 715, 72, 213, 715, 72, 213, 715, 72};
    localparam int COS_K  [NUM_COEF] = '{787, -715, -72, -213, 285, -72, -213, -715, 928};
    localparam int SIN_K  [NUM_COEF] = '{-213, -715, 928, 143, 140, -283, -787, 715, 72};

    // largest base term and largest |cos k| + |sin k| over the nine coefficients
    localparam int BASE_MAX = 715;
    localparam int KSUM_MAX = 1430;

    // rounding divide by 1000: a bias keeps the dividend non-negative
    localparam longint CFG_MAG    = longint'(1) << (CFG_W - 1);
    localparam longint DIV_BIAS   = (longint'(KSUM_MAX) * CFG_MAG) / 1000 + 1;
    localparam longint DIV_OFFSET = 500 + 1000 * DIV_BIAS;
    localparam longint Y_MAX      = longint'(BASE_MAX) * (longint'(1) << FRAC_BITS)
                                    + longint'(KSUM_MAX) * CFG_MAG + DIV_OFFSET;
    localparam int     Y_W        = $clog2(Y_MAX + 1);
    localparam int     X_W        = Y_W + 1;

    // reciprocal of 1000, exact for every dividend below 2^Y_W
    localparam int     DIV_SHIFT  = Y_W + 10;
    localparam longint DIV_MUL    = ((longint'(1) << DIV_SHIFT) + 999) / 1000;
    localparam int     MUL_W      = Y_W + 1;

    // coefficient, product and dot-product widths
    localparam int COEF_W = $clog2(Y_MAX / 1000 + 1) + 1;
    localparam int DIVP_W = DIV_SHIFT + COEF_W - 1;
    localparam int PROD_W = COEF_W + CH_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // settle count loaded on a register write; the coefficient bank is settled once it reaches zero
    localparam int SETTLE_CYC = 2;
    localparam int SETTLE_W   = $clog2(SETTLE_CYC + 1);

    typedef logic signed [COEF_W-1:0] coef_t;

    typedef struct packed {
        coef_t [NUM_COEF-1:0] m;
        logic                 busy;
    } coef_bank_t;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
    } pixel_in_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
    } pixel_out_t;

endpackage

`default_nettype wire

FILE: hdl/hrc_coef.sv
// angle registers and the pipelined build of the nine matrix coefficients
`default_nettype none

module hrc_coef
    import hrc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output coef_bank_t                bank
);

    logic signed [CFG_W-1:0]  cos_reg;
    logic signed [CFG_W-1:0]  sin_reg;
    logic [SETTLE_W-1:0]      settle_reg;
    logic [SETTLE_W-1:0]      settle_next;
    logic [Y_W-1:0]           y_reg    [NUM_COEF];
    logic [Y_W-1:0]           y_next   [NUM_COEF];
    coef_t                    coef_reg [NUM_COEF];
    coef_t                    coef_next[NUM_COEF];
    logic signed [X_W-1:0]    cos_x;
    logic signed [X_W-1:0]    sin_x;
    logic signed [X_W-1:0]    x_sum    [NUM_COEF];
    logic [DIVP_W-1:0]        divp     [NUM_COEF];

    // angle registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg <= CFG_W'(longint'(1) << FRAC_BITS);
            sin_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_e'(cfg_index))
                CFG_COS_ANGLE: cos_reg <= cfg_data;
                CFG_SIN_ANGLE: sin_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // settle counter: bank not usable until the two stages below have refilled
    always_comb
    begin
        settle_next = settle_reg;
        if (cfg_we)
            settle_next = SETTLE_W'(SETTLE_CYC);
        else if (settle_reg != '0)
            settle_next = settle_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            settle_reg <= SETTLE_W'(SETTLE_CYC);
        else
            settle_reg <= settle_next;
    end

    // first stage: base * one + kc * cos + ks * sin, rounding and bias folded in
    assign cos_x = X_W'(cos_reg);
    assign sin_x = X_W'(sin_reg);

    for (genvar i = 0; i < NUM_COEF; i++)
    begin : g_coef
        assign x_sum[i] = X_W'(longint'(BASE_K[i]) * (longint'(1) << FRAC_BITS) + DIV_OFFSET)
                          + X_W'(COS_K[i]) * cos_x
                          + X_W'(SIN_K[i]) * sin_x;
        assign y_next[i] = x_sum[i][Y_W-1:0];

        // second stage: floor divide by 1000 through the reciprocal, then unbias
        assign divp[i] = DIVP_W'(y_reg[i]) * DIVP_W'($unsigned(MUL_W'(DIV_MUL)));
        assign coef_next[i] = coef_t'({1'b0, divp[i][DIV_SHIFT +: COEF_W-1]})
                              - coef_t'(DIV_BIAS);

        always_ff @(posedge clk)
        begin
            y_reg[i]    <= y_next[i];
            coef_reg[i] <= coef_next[i];
        end

        assign bank.m[i] = coef_reg[i];
    end

    assign bank.busy = (settle_reg != '0);

    // a write always holds the bank busy for the settle time
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> bank.busy)
        else $error("coefficient bank not busy after register write");

    a_busy_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we && settle_reg != '0 |=> settle_reg == $past(settle_reg) - 1'b1)
        else $error("settle counter skipped a step");

endmodule

`default_nettype wire

FILE: hdl/hrc_lane.sv
// one output channel: three products, dot-product sum, floor and saturate
`default_nettype none

module hrc_lane
    import hrc_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     load,
    input  wire coef_t [2:0]              row,
    input  wire logic [2:0][CH_W-1:0]     chan,
    output logic [CH_W-1:0]               level
);

    logic signed [PROD_W-1:0] prod_reg [3];
    logic signed [PROD_W-1:0] prod_next[3];
    logic signed [SUM_W-1:0]  acc;

    // products of the row coefficients with r, g and b
    for (genvar k = 0; k < 3; k++)
    begin : g_prod
        assign prod_next[k] = PROD_W'($signed(row[k]))
                              * PROD_W'($signed({1'b0, chan[k]}));

        always_ff @(posedge clk)
        begin
            if (load)
                prod_reg[k] <= prod_next[k];
        end
    end

    // sum, floor by dropping fraction bits, clamp to 0..255
    assign acc = SUM_W'(prod_reg[0]) + SUM_W'(prod_reg[1]) + SUM_W'(prod_reg[2]);

    always_comb
    begin
        if (acc[SUM_W-1])
            level = '0;
        else if (|acc[SUM_W-2:FRAC_BITS+CH_W])
            level = '1;
        else
            level = acc[FRAC_BITS +: CH_W];
    end

endmodule

`default_nettype wire

FILE: hdl/hue_rotate_color_matrix.sv
// top level: hue-rotate colour matrix on a stream of rgba pixels
//
//  channel   direction  handshake           payload
//  pix_in    in         in_valid/in_ready   pixel_in_t  (r, g, b, a)
//  pix_out   out        out_valid/out_ready pixel_out_t (r, g, b, a)
//  cfg       in         cfg_we              cfg_index, cfg_data (cos, sin)
//
// one beat per clock sustained while out_ready is high and the bank is not busy;
// a beat passes the input register, lane product register and output register
// after reset and after every register write, in_ready stays low
// while the coefficient bank (sum stage, reciprocal-multiply stage) refills
// each stage holds when the one after it is full and stalled, so bubbles close up
// and new beats are taken while a result waits on out_ready
`default_nettype none

module hue_rotate_color_matrix
    import hrc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pixel_in_t            pix_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pixel_out_t                pix_out,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    coef_bank_t             bank;
    logic                   s1_valid_reg;
    pixel_in_t              s1_pix_reg;
    logic                   s2_valid_reg;
    logic [CH_W-1:0]        s2_alpha_reg;
    logic                   out_valid_reg;
    pixel_out_t             out_pix_reg;
    pixel_out_t             out_pix_next;
    logic                   out_adv;
    logic                   s2_adv;
    logic                   s1_adv;
    logic                   in_fire;
    logic [2:0][CH_W-1:0]   chan;
    logic [NUM_LANES-1:0][CH_W-1:0] level;

    // coefficient bank
    hrc_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bank      (bank)
    );

    // stage advance chain
    assign out_adv  = !out_valid_reg || out_ready;
    assign s2_adv   = !s2_valid_reg || out_adv;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv && !bank.busy;
    assign in_fire  = in_valid && in_ready;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
                s1_valid_reg <= in_fire;
            if (s2_adv)
                s2_valid_reg <= s1_valid_reg;
            if (out_adv)
                out_valid_reg <= s2_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (in_fire)
            s1_pix_reg <= pix_in;
    end

    // lanes, one per colour channel
    assign chan[0] = s1_pix_reg.red_in;
    assign chan[1] = s1_pix_reg.green_in;
    assign chan[2] = s1_pix_reg.blue_in;

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        hrc_lane u_lane (
            .clk   (clk),
            .load  (s2_adv),
            .row   (bank.m[3*i +: 3]),
            .chan  (chan),
            .level (level[i])
        );
    end

    always_ff @(posedge clk)
    begin
        if (s2_adv)
            s2_alpha_reg <= s1_pix_reg.alpha_in;
    end

    // merge lane results with alpha into the output register
    always_comb
    begin
        out_pix_next.red_out   = level[0];
        out_pix_next.green_out = level[1];
        out_pix_next.blue_out  = level[2];
        out_pix_next.alpha_out = s2_alpha_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv)
            out_pix_reg <= out_pix_next;
    end

    assign out_valid = out_valid_reg;
    assign pix_out   = out_pix_reg;

    // no beat taken while coefficients settle after a write
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !in_ready)
        else $error("input beat possible right after register write");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted beat lost at input register");

    a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s2_valid_reg))
        else $error("output beat appeared without a lane result");

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// testbench for the hue-rotate colour matrix: directed and random pixels checked against a predictor
`timescale 1ns / 100ps

module testbench;
    import hrc_pkg::*;

    // fraction bits of the angle registers and of the matrix coefficients
    localparam int ANGLE_FRAC = 14;
    // cycles with no beat moving before the run is called hung
    localparam int STALL_LIMIT = 400;
    localparam int PHASE_PIXELS = 150;
    localparam int NUM_PHASES = 11;

    // matrix terms in thousandths, red row, green row, blue row
    localparam longint K_BASE [9] = '{213, 715, 72, 213, 715, 72, 213, 715, 72};
    localparam longint K_COS  [9] = '{787, -715, -72, -213, 285, -72, -213, -715, 928};
    localparam longint K_SIN  [9] = '{-213, -715, 928, 143, 140, -283, -787, 715, 72};

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    pixel_in_t            pix_in;
    logic                 out_valid;
    logic                 out_ready;
    pixel_out_t           pix_out;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    // expected rotated pixels, in the order the input beats were taken
    class pixel_scoreboard;
        logic signed [15:0] cos_reg;
        logic signed [15:0] sin_reg;
        pixel_out_t         rotated_q[$];
        int                 mismatches;
        int                 compared;

        function new();
            cos_reg    = 16'sd16384;
            sin_reg    = 16'sd0;
            mismatches = 0;
            compared   = 0;
        endfunction

        function void set_angles(logic signed [15:0] c, logic signed [15:0] s);
            cos_reg = c;
            sin_reg = s;
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction

        // coefficients rounded half up to the fraction grid, then floored dot products
        function pixel_out_t rotate_pixel(pixel_in_t p);
            longint     coef [9];
            longint     chan [3];
            longint     num;
            longint     q;
            longint     acc;
            logic [7:0] lane [3];
            pixel_out_t r;
            for (int i = 0; i < 9; i++)
            begin
                num = K_BASE[i] * (longint'(1) << ANGLE_FRAC) + K_COS[i] * longint'(cos_reg)
                      + K_SIN[i] * longint'(sin_reg) + 500;
                q = num / 1000;
                if ((num % 1000) != 0 && num < 0)
                    q = q - 1;
                coef[i] = q;
            end
            chan[0] = longint'(p.red_in);
            chan[1] = longint'(p.green_in);
            chan[2] = longint'(p.blue_in);
            for (int i = 0; i < 3; i++)
            begin
                acc = coef[3*i] * chan[0] + coef[3*i+1] * chan[1] + coef[3*i+2] * chan[2];
                if (acc < 0)
                    lane[i] = 8'd0;
                else if ((acc >>> ANGLE_FRAC) > 255)
                    lane[i] = 8'd255;
                else
                    lane[i] = 8'(acc >>> ANGLE_FRAC);
            end
            r.red_out   = lane[0];
            r.green_out = lane[1];
            r.blue_out  = lane[2];
            r.alpha_out = p.alpha_in;
            return r;
        endfunction

        function void note_pixel(pixel_in_t p);
            rotated_q.push_back(rotate_pixel(p));
        endfunction

        function void check_pixel(pixel_out_t got);
            pixel_out_t want;
            if (rotated_q.size() == 0)
            begin
                $error("output beat %h with no pixel outstanding", got);
                mismatches++;
                return;
            end
            want = rotated_q.pop_front();
            compared++;
            if (got.red_out !== want.red_out)
            begin
                $error("red_out: expected %0d, got %0d", want.red_out, got.red_out);
                mismatches++;
            end
            if (got.green_out !== want.green_out)
            begin
                $error("green_out: expected %0d, got %0d", want.green_out, got.green_out);
                mismatches++;
            end
            if (got.blue_out !== want.blue_out)
            begin
                $error("blue_out: expected %0d, got %0d", want.blue_out, got.blue_out);
                mismatches++;
            end
            if (got.alpha_out !== want.alpha_out)
            begin
                $error("alpha_out: expected %0d, got %0d", want.alpha_out, got.alpha_out);
                mismatches++;
            end
        endfunction
    endclass

    pixel_scoreboard sb;
    bit              no_idle;
    int              pixels_taken;
    int              angle_settings;
    int              idle_run;

    hue_rotate_color_matrix dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pix_in    (pix_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pix_out   (pix_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // beat monitor: results checked first, then newly taken pixels noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_pixel(pix_out);
            if (in_valid && in_ready)
            begin
                sb.note_pixel(pix_in);
                pixels_taken++;
            end
        end
    end

    // watchdog on cycles where nothing moves
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_run = 0;
            else
                idle_run++;
            if (idle_run >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 7);
    endfunction

    // channel values lean towards the extremes to hit saturation and zero clamps
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_in_t random_pixel();
        pixel_in_t p;
        p.red_in   = random_channel();
        p.green_in = random_channel();
        p.blue_in  = random_channel();
        p.alpha_in = random_channel();
        return p;
    endfunction

    // corner pixels: black, white, pure primaries, alpha only, bit patterns
    function automatic pixel_in_t corner_pixel(int k);
        case (k)
            0:       return {8'h00, 8'h00, 8'h00, 8'h00};
            1:       return {8'hff, 8'hff, 8'hff, 8'hff};
            2:       return {8'hff, 8'h00, 8'h00, 8'h80};
            3:       return {8'h00, 8'hff, 8'h00, 8'h7f};
            4:       return {8'h00, 8'h00, 8'hff, 8'h01};
            5:       return {8'h00, 8'h00, 8'h00, 8'hff};
            6:       return {8'h55, 8'haa, 8'h55, 8'haa};
            7:       return {8'haa, 8'h55, 8'haa, 8'h55};
            8:       return {8'h80, 8'h80, 8'h80, 8'hfe};
            9:       return {8'h01, 8'hfe, 8'h01, 8'h00};
            10:      return {8'hff, 8'hff, 8'h00, 8'hc3};
            default: return {8'h00, 8'hff, 8'hff, 8'h3c};
        endcase
    endfunction

    // one input beat after a random gap
    task automatic send_pixel(input pixel_in_t p);
        int gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        pix_in   <= p;
        do @(posedge clk); while (!in_ready);
    endtask

    // drop valid and wait until every rotated pixel has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // both angle registers, written back to back while the block is idle
    task automatic write_angles(input logic signed [15:0] c, input logic signed [15:0] s);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_COS_ANGLE;
        cfg_data  <= c;
        @(negedge clk);
        cfg_index <= CFG_SIN_ANGLE;
        cfg_data  <= s;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_angles(c, s);
        angle_settings++;
    endtask

    // output side: random stall before each beat
    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap();
            if (stall != 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                out_ready <= 1'b1;
            end
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    initial
    begin
        logic signed [15:0] c;
        logic signed [15:0] s;
        sb             = new();
        no_idle        = 1'b0;
        pixels_taken   = 0;
        angle_settings = 1;
        idle_run       = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        pix_in         = '0;
        out_ready      = 1'b1;
        cfg_we         = 1'b0;
        cfg_index      = CFG_COS_ANGLE;
        cfg_data       = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corner pixels at the reset angle, then at 180 degrees for negative clamps
        for (int k = 0; k < 12; k++)
            send_pixel(corner_pixel(k));
        drain();
        write_angles(-16'sd16384, 16'sd0);
        for (int k = 0; k < 8; k++)
            send_pixel(corner_pixel(k));
        drain();

        // random pixels over a spread of angles, out-of-range registers among them
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:  begin c = -16'sd16384; s = 16'sd0;      end
                1:  begin c = 16'sd0;      s = 16'sd16384;  end
                2:  begin c = 16'sd0;      s = -16'sd16384; end
                3:  begin c = 16'sd11585;  s = 16'sd11585;  end
                4:  begin c = -16'sd8192;  s = 16'sd14189;  end
                5:  begin c = 16'sh7fff;   s = 16'sh8000;   end
                6:  begin c = 16'sh8000;   s = 16'sh7fff;   end
                7, 8:
                begin
                    c = 16'($urandom_range(0, 32768) - 16384);
                    s = 16'($urandom_range(0, 32768) - 16384);
                end
                9:
                begin
                    c = 16'($urandom_range(0, 65535));
                    s = 16'($urandom_range(0, 65535));
                end
                default: begin c = 16'sd16384; s = 16'sd0; end
            endcase
            no_idle = (ph == 3) || (ph == 8);
            write_angles(c, s);
            repeat (PHASE_PIXELS) send_pixel(random_pixel());
            drain();
        end

        repeat (10) @(posedge clk);
        $display("%0d pixels rotated under %0d angle settings, corners and saturating angles included",
                 pixels_taken, angle_settings);
        $display("%0d output beats compared, %0d field mismatches", sb.compared, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
